>>> design/stable_sorted_priority_queue_top_macros.svh
// Assertion macros shared by the priority queue RTL.
`ifndef STABLE_SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check an expression at every clock edge outside reset.
`define SSPQ_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Check that a condition implies a result in the following cycle.
`define SSPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SSPQ_ASSERT_ALWAYS(lbl, expr, msg)
`define SSPQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> design/sspq_pkg.sv
// Types and constants of the sorted priority queue.
package sspq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int LEVEL_BITS  = 4;
  localparam int TAG_BITS    = 16;
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
  localparam int OCC_BITS    = 7;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    kind_t                 kind;
    logic [TAG_BITS-1:0]   tag;
    logic [LEVEL_BITS-1:0] level;
  } in_item_t;

  typedef struct packed {
    status_t               status;
    logic [TAG_BITS-1:0]   head_tag;
    logic [LEVEL_BITS-1:0] head_level;
    logic [OCC_BITS-1:0]   occupancy;
  } out_item_t;

  // One stored entry, handed between neighboring cells.
  typedef struct packed {
    logic [TAG_BITS-1:0]   tag;
    logic [LEVEL_BITS-1:0] level;
  } entry_t;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t item;
  } cell_cmd_t;

endpackage

>>> design/sspq_cell.sv
// One cell of the sorted row: holds one entry and trades it with its neighbors.
module sspq_cell (
  input  logic               clk,
  input  sspq_pkg::cell_cmd_t cmd,
  input  logic               occ,
  input  logic               left_keep,
  input  sspq_pkg::entry_t   left_entry,
  input  sspq_pkg::entry_t   right_entry,
  output logic               keep,
  output sspq_pkg::entry_t   entry
);
  import sspq_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  // Keep this entry on insert when it sorts at or ahead of the new one
  assign keep  = occ && (entry_r.level <= cmd.item.level);
  assign entry = entry_r;

  // Select hold, new item, shift right on insert or shift left on remove
  always_comb begin
    entry_nxt = entry_r;
    if (cmd.ins) begin
      if (keep) begin
        entry_nxt = entry_r;
      end else if (left_keep) begin
        entry_nxt = cmd.item;
      end else begin
        entry_nxt = left_entry;
      end
    end else if (cmd.rem) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

>>> design/stable_sorted_priority_queue_top.sv
// Top level of the stable sorted priority queue.
//
// Input channel in_valid/in_ready/in_data carries one command per transfer:
// an insert (tag and level) or a remove of the head entry. Output channel
// out_valid/out_ready/out_data returns exactly one result per command: the
// status, the removed tag and level (zero unless an entry was removed) and
// the occupancy after the command.
// Entries sit in a row of QUEUE_DEPTH cells kept sorted by level; equal
// levels leave in arrival order. An insert is broadcast to all cells, each
// cell keeps, takes the new entry or takes its left neighbor's entry; a
// remove shifts every cell one place toward the head.
// The result is in the output register in the cycle after the input
// transfer. Throughput: one command per cycle while the receiver keeps up,
// since the whole cell row updates on each transfer.
// Insert into a full queue drops the item and reports full; remove from an
// empty queue reports empty. Reset empties the queue at once, with no
// clearing pass. When the receiver stalls, the result holds in the output
// register and in_ready drops until it is taken.
`include "stable_sorted_priority_queue_top_macros.svh"
module stable_sorted_priority_queue_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sspq_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sspq_pkg::out_item_t  out_data
);
  import sspq_pkg::*;

  logic [CNT_BITS-1:0] count_r;
  logic [CNT_BITS-1:0] count_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  out_item_t           out_data_r;
  out_item_t           out_data_nxt;

  logic      in_fire;
  logic      is_full;
  logic      is_empty;
  cell_cmd_t cmd;

  logic   [QUEUE_DEPTH-1:0] occ;
  logic   [QUEUE_DEPTH-1:0] keep;
  entry_t                   entries [QUEUE_DEPTH];

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign is_full  = (count_r == CNT_BITS'(QUEUE_DEPTH));
  assign is_empty = (count_r == '0);

  // Build the command broadcast to the cell row
  always_comb begin
    cmd.ins        = in_fire && (in_data.kind == KIND_INSERT) && !is_full;
    cmd.rem        = in_fire && (in_data.kind == KIND_REMOVE) && !is_empty;
    cmd.item.tag   = in_data.tag;
    cmd.item.level = in_data.level;
  end

  // Instantiate the row of cells
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic   left_keep;
    entry_t left_entry;
    entry_t right_entry;

    assign occ[i] = (CNT_BITS'(i) < count_r);

    if (i == 0) begin : g_head
      assign left_keep  = 1'b1;
      assign left_entry = cmd.item;
    end else begin : g_body
      assign left_keep  = keep[i-1];
      assign left_entry = entries[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_entry = entries[i];
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end

    sspq_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occ         (occ[i]),
      .left_keep   (left_keep),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .keep        (keep[i]),
      .entry       (entries[i])
    );
  end

  // Advance the occupancy count
  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + CNT_BITS'(1);
    end else if (cmd.rem) begin
      count_nxt = count_r - CNT_BITS'(1);
    end
  end

  // Form the result and load it on transfer, drop valid once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.head_tag   = '0;
      out_data_nxt.head_level = '0;
      out_data_nxt.occupancy  = OCC_BITS'(count_nxt);
      if (in_data.kind == KIND_INSERT) begin
        out_data_nxt.status = is_full ? ST_FULL : ST_INSERTED;
      end else if (is_empty) begin
        out_data_nxt.status = ST_EMPTY;
      end else begin
        out_data_nxt.status     = ST_REMOVED;
        out_data_nxt.head_tag   = entries[0].tag;
        out_data_nxt.head_level = entries[0].level;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SSPQ_ASSERT_ALWAYS(a_count_bound, count_r <= CNT_BITS'(QUEUE_DEPTH), "count beyond depth")
  `SSPQ_ASSERT_ALWAYS(a_occ_match, !out_valid_r || (out_data_r.occupancy == OCC_BITS'(count_r)), "occupancy differs from count")
  `SSPQ_ASSERT_NEXT(a_fire_result, in_fire, out_valid_r, "accepted command gave no result")
  `SSPQ_ASSERT_NEXT(a_remove_count, cmd.rem, count_r == $past(count_r) - CNT_BITS'(1), "remove did not drop count")
  `SSPQ_ASSERT_NEXT(a_full_hold, in_fire && is_full && (in_data.kind == KIND_INSERT), count_r == $past(count_r) && out_data_r.status == ST_FULL, "full insert changed queue")

endmodule
